### hdl/atfp_pkg.sv
package atfp_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW = $clog2(QueueDepth);

   localparam logic [15:0] MaxPayload = 16'd65521;
   localparam logic [15:0] LenOverhead = 16'd14;

   localparam logic [7:0] StartByte = 8'h7E;
   localparam logic [7:0] TypeByte = 8'h10;
   localparam logic [7:0] Reserved1 = 8'hFF;
   localparam logic [7:0] Reserved2 = 8'hFE;
   localparam logic [7:0] CheckInit = 8'hFF;

   // register indexes
   localparam logic [1:0] RegPayloadLength = 2'd0;
   localparam logic [1:0] RegDestAddress = 2'd1;
   localparam logic [1:0] RegHopRadius = 2'd2;
   localparam logic [1:0] RegTxOptions = 2'd3;

   // back-end steps: header bytes, then payload, then checksum
   localparam logic [4:0] StepStart = 5'd0;
   localparam logic [4:0] StepLenHi = 5'd1;
   localparam logic [4:0] StepLenLo = 5'd2;
   localparam logic [4:0] StepType = 5'd3;
   localparam logic [4:0] StepId = 5'd4;
   localparam logic [4:0] StepDest0 = 5'd5;
   localparam logic [4:0] StepDest7 = 5'd12;
   localparam logic [4:0] StepRes1 = 5'd13;
   localparam logic [4:0] StepRes2 = 5'd14;
   localparam logic [4:0] StepRadius = 5'd15;
   localparam logic [4:0] StepOptions = 5'd16;
   localparam logic [4:0] StepPayload = 5'd17;
   localparam logic [4:0] StepCheck = 5'd18;

   typedef struct packed {
      logic [15:0] payload_length;
      logic [63:0] dest_address;
      logic [7:0]  hop_radius;
      logic [7:0]  tx_options;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic [7:0] msg_id;
   } entry_type;

   function automatic logic [15:0] eff_length(input logic [15:0] len);
      logic [15:0] n;
      n = len;
      if (n == 16'd0) begin
         n = 16'd1;
      end
      if (n > MaxPayload) begin
         n = MaxPayload;
      end
      return n;
   endfunction

endpackage

### hdl/atfp_if.sv
interface atfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;

   modport source (output valid, output payload_byte, input ready);
   modport sink (input valid, input payload_byte, output ready);
endinterface

interface atfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

### hdl/atfp_queue.sv
module atfp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  atfp_pkg::entry_type   push_data,
   output logic                  full,
   input  logic                  pop,
   output atfp_pkg::entry_type   head,
   output logic                  empty
);

   atfp_pkg::entry_type mem_ff [atfp_pkg::QueueDepth];
   logic [atfp_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [atfp_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [atfp_pkg::QueuePtrW:0]   count_ff, count_in;

   assign full  = (count_ff == (atfp_pkg::QueuePtrW+1)'(atfp_pkg::QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/atfp_front.sv
module atfp_front (
   input  logic                clock,
   input  logic                reset,
   input  atfp_pkg::cfg_type   cfg,
   atfp_req_if.sink            req_chan,
   output logic                push,
   output atfp_pkg::entry_type push_data,
   input  logic                q_full
);

   logic [7:0]  msg_id_ff, msg_id_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic [15:0] n;
   logic [7:0]  next_id;
   logic        first;
   logic        last;

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   always_comb begin
      n       = atfp_pkg::eff_length(cfg.payload_length);
      first   = (byte_index_ff == 16'd0);
      last    = ({1'b0, byte_index_ff} + 17'd1) >= {1'b0, n};
      next_id = msg_id_ff + 8'd1;
      if (next_id == 8'd0) begin
         next_id = 8'd1;
      end
      msg_id_in     = msg_id_ff;
      byte_index_in = byte_index_ff;
      if (push) begin
         if (first) begin
            msg_id_in = next_id;
         end
         byte_index_in = last ? 16'd0 : byte_index_ff + 16'd1;
      end
      push_data.data   = req_chan.payload_byte;
      push_data.first  = first;
      push_data.last   = last;
      push_data.msg_id = first ? next_id : msg_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_id_ff     <= 8'd0;
         byte_index_ff <= 16'd0;
      end else begin
         msg_id_ff     <= msg_id_in;
         byte_index_ff <= byte_index_in;
      end
   end

endmodule

### hdl/atfp_back.sv
module atfp_back (
   input  logic                clock,
   input  logic                reset,
   input  atfp_pkg::cfg_type   cfg,
   input  atfp_pkg::entry_type head,
   input  logic                q_empty,
   output logic                pop,
   atfp_rsp_if.source          rsp_chan
);

   logic [4:0]  step_ff, step_in;
   logic        started_ff, started_in;
   logic [7:0]  running_ff, running_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_end_ff, rsp_end_in;
   logic [4:0]  step;
   logic        emit;
   logic        summed;
   logic [7:0]  out_byte;
   logic [15:0] frame_len;
   logic [2:0]  dest_k;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.frame_byte = rsp_byte_ff;
   assign rsp_chan.frame_end  = rsp_end_ff;

   always_comb begin
      step      = started_ff ? step_ff
                             : (head.first ? atfp_pkg::StepStart : atfp_pkg::StepPayload);
      emit      = !q_empty && (!rsp_valid_ff || rsp_chan.ready);
      frame_len = atfp_pkg::LenOverhead + atfp_pkg::eff_length(cfg.payload_length);
      dest_k    = 3'(step - atfp_pkg::StepDest0);
      summed    = (step >= atfp_pkg::StepType) && (step <= atfp_pkg::StepPayload);

      case (step)
         atfp_pkg::StepStart:   out_byte = atfp_pkg::StartByte;
         atfp_pkg::StepLenHi:   out_byte = frame_len[15:8];
         atfp_pkg::StepLenLo:   out_byte = frame_len[7:0];
         atfp_pkg::StepType:    out_byte = atfp_pkg::TypeByte;
         atfp_pkg::StepId:      out_byte = head.msg_id;
         atfp_pkg::StepRes1:    out_byte = atfp_pkg::Reserved1;
         atfp_pkg::StepRes2:    out_byte = atfp_pkg::Reserved2;
         atfp_pkg::StepRadius:  out_byte = cfg.hop_radius;
         atfp_pkg::StepOptions: out_byte = cfg.tx_options;
         atfp_pkg::StepPayload: out_byte = head.data;
         atfp_pkg::StepCheck:   out_byte = running_ff;
         default: begin
            // destination, most significant byte first
            out_byte = 8'(cfg.dest_address >> {3'(3'd7 - dest_k), 3'b000});
         end
      endcase

      pop = emit && ((step == atfp_pkg::StepPayload && !head.last)
                     || step == atfp_pkg::StepCheck);

      step_in    = step_ff;
      started_in = started_ff;
      running_in = running_ff;
      if (emit) begin
         if (pop) begin
            started_in = 1'b0;
            step_in    = atfp_pkg::StepStart;
         end else begin
            started_in = 1'b1;
            step_in    = step + 5'd1;
         end
         if (step == atfp_pkg::StepStart || step == atfp_pkg::StepCheck) begin
            running_in = atfp_pkg::CheckInit;
         end else if (summed) begin
            running_in = running_ff - out_byte;
         end
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rsp_byte_in  = emit ? out_byte : rsp_byte_ff;
      rsp_end_in   = emit ? (step == atfp_pkg::StepCheck) : rsp_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= atfp_pkg::StepStart;
         started_ff   <= 1'b0;
         running_ff   <= atfp_pkg::CheckInit;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         started_ff   <= started_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   a_check_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && step == atfp_pkg::StepCheck) |=> (running_ff == atfp_pkg::CheckInit))
      else $error("checksum not restarted after frame end");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> !q_empty)
      else $error("request left the queue mid-sequence");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (step_ff != atfp_pkg::StepStart && step_ff <= atfp_pkg::StepCheck))
      else $error("sequencer step out of range");

   a_end_only_check: assert property (@(posedge clock) disable iff (reset)
      (emit && step != atfp_pkg::StepCheck) |=> !rsp_end_ff)
      else $error("frame end flagged on a non-checksum byte");

endmodule

### hdl/api_transmit_frame_packer.sv
// Transmit-request frame packer.
// req_chan carries payload bytes, one request per byte. rsp_chan returns the
// frame bytes in order; frame_end marks the checksum byte closing a frame.
// The csr_ port writes payload_length (0), dest_address (1), hop_radius (2)
// and tx_options (3); write only while no request is in flight.
// The first byte a request causes passes through the queue and the output
// register before it is valid on rsp_chan, once the output is free. A request
// that opens a frame yields 17 header bytes plus its payload byte, and the
// checksum byte too if it also ends the frame; other requests yield their
// payload byte, plus the closing checksum when they end the frame. A single
// output sequencer emits these bytes; a four-entry queue sits between the input
// side and the sequencer, so req_chan keeps accepting while the header drains.
// Reset (synchronous, active high) empties the queue, restores the register
// defaults (53, 0xFFFF, 0, 0) and restarts frame ids at 1.
// When the receiver holds rsp_chan.ready low the output byte holds, the
// sequencer pauses and, once the queue fills, req_chan.ready drops.
module api_transmit_frame_packer (
   input  logic        clock,
   input  logic        reset,
   atfp_req_if.sink    req_chan,
   atfp_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   atfp_pkg::cfg_type   cfg_ff, cfg_in;
   atfp_pkg::entry_type push_data;
   atfp_pkg::entry_type head;
   logic                push;
   logic                pop;
   logic                q_full;
   logic                q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            atfp_pkg::RegPayloadLength: cfg_in.payload_length = csr_wdata[15:0];
            atfp_pkg::RegDestAddress:   cfg_in.dest_address   = csr_wdata;
            atfp_pkg::RegHopRadius:     cfg_in.hop_radius     = csr_wdata[7:0];
            atfp_pkg::RegTxOptions:     cfg_in.tx_options     = csr_wdata[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.payload_length <= 16'd53;
         cfg_ff.dest_address   <= 64'd65535;
         cfg_ff.hop_radius     <= 8'd0;
         cfg_ff.tx_options     <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   atfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   atfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty)
   );

   atfp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### sim/api_transmit_frame_packer_tb.sv
`timescale 1ns / 100ps

module api_transmit_frame_packer_tb;

   localparam int CycleLimit = 1_500_000;
   localparam int NumRows = 32;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } frame_out_type;

   typedef enum logic {RowSend, RowWrite} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [1:0]   index;
      logic [63:0]  value;
      int           exp_len;
      int           exp_id;
   } row_type;

   // exp_len / exp_id of -1: taken from the frame predictor
   row_type directed_rows [NumRows] = '{
      '{RowSend,  '0,                         64'h00,                  67,    1},
      '{RowSend,  '0,                         64'hFF,                  -1,   -1},
      '{RowSend,  '0,                         64'hA5,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegPayloadLength, 64'd2,                   -1,   -1},
      '{RowSend,  '0,                         64'h5A,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegDestAddress,   64'hFFFF_FFFF_FFFF_FFFF, -1,   -1},
      '{RowWrite, atfp_pkg::RegHopRadius,     64'hFF,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegTxOptions,     64'hFF,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegPayloadLength, 64'd0,                   -1,   -1},
      '{RowSend,  '0,                         64'hFF,                  15,    2},
      '{RowWrite, atfp_pkg::RegDestAddress,   64'h0,                   -1,   -1},
      '{RowWrite, atfp_pkg::RegHopRadius,     64'h0,                   -1,   -1},
      '{RowWrite, atfp_pkg::RegTxOptions,     64'h0,                   -1,   -1},
      '{RowSend,  '0,                         64'h00,                  15,    3},
      '{RowWrite, atfp_pkg::RegPayloadLength, 64'd65535,               -1,   -1},
      '{RowSend,  '0,                         64'h81,                  65535, 4},
      '{RowSend,  '0,                         64'h7E,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegPayloadLength, 64'd65521,               -1,   -1},
      '{RowSend,  '0,                         64'h01,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegPayloadLength, 64'd65522,               -1,   -1},
      '{RowSend,  '0,                         64'h80,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegPayloadLength, 64'd3,                   -1,   -1},
      '{RowSend,  '0,                         64'h3C,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegPayloadLength, 64'd1,                   -1,   -1},
      '{RowWrite, atfp_pkg::RegDestAddress,   64'h0123_4567_89AB_CDEF, -1,   -1},
      '{RowWrite, atfp_pkg::RegHopRadius,     64'h1E,                  -1,   -1},
      '{RowWrite, atfp_pkg::RegTxOptions,     64'h01,                  -1,   -1},
      '{RowSend,  '0,                         64'h10,                  15,    5},
      '{RowSend,  '0,                         64'hFE,                  15,    6},
      '{RowWrite, atfp_pkg::RegPayloadLength, 64'd2,                   -1,   -1},
      '{RowSend,  '0,                         64'h7F,                  16,    7},
      '{RowSend,  '0,                         64'hC3,                  -1,   -1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic [7:0]  req_byte = 8'h00;
   logic        rsp_ready = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = atfp_pkg::RegPayloadLength;
   logic [63:0] csr_wdata = 64'h0;

   bit          idle_on = 1'b1;
   int unsigned ready_hold = 0;
   int unsigned cycles = 0;
   int unsigned mismatches = 0;

   // frame predictor state
   logic [15:0] cfg_payload_len = 16'd53;
   logic [63:0] cfg_dest = 64'hFFFF;
   logic [7:0]  cfg_radius = 8'h00;
   logic [7:0]  cfg_options = 8'h00;
   logic [7:0]  pred_msg_id = 8'h00;
   logic [15:0] pred_byte_count = 16'd0;
   logic [7:0]  pred_check = atfp_pkg::CheckInit;

   frame_out_type frame_bytes_due [$];

   atfp_req_if req_if ();
   atfp_rsp_if rsp_if ();

   assign req_if.valid = req_valid;
   assign req_if.payload_byte = req_byte;
   assign rsp_if.ready = rsp_ready;

   api_transmit_frame_packer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void emit_byte(input logic [7:0] b, input bit summed, input bit last);
      frame_bytes_due.push_back('{frame_byte: b, frame_end: last});
      if (summed) begin
         pred_check = pred_check - b;
      end
   endfunction

   function automatic void pack_byte(input logic [7:0] pb);
      logic [15:0] n;
      logic [15:0] len_field;
      n = cfg_payload_len;
      if (n == 16'd0) begin
         n = 16'd1;
      end
      if (n > atfp_pkg::MaxPayload) begin
         n = atfp_pkg::MaxPayload;
      end
      if (pred_byte_count == 16'd0) begin
         pred_msg_id = pred_msg_id + 8'd1;
         if (pred_msg_id == 8'd0) begin
            pred_msg_id = 8'd1;
         end
         pred_check = atfp_pkg::CheckInit;
         len_field = atfp_pkg::LenOverhead + n;
         emit_byte(atfp_pkg::StartByte, 1'b0, 1'b0);
         emit_byte(len_field[15:8], 1'b0, 1'b0);
         emit_byte(len_field[7:0], 1'b0, 1'b0);
         emit_byte(atfp_pkg::TypeByte, 1'b1, 1'b0);
         emit_byte(pred_msg_id, 1'b1, 1'b0);
         for (int k = 7; k >= 0; k--) begin
            emit_byte(cfg_dest[k*8 +: 8], 1'b1, 1'b0);
         end
         emit_byte(atfp_pkg::Reserved1, 1'b1, 1'b0);
         emit_byte(atfp_pkg::Reserved2, 1'b1, 1'b0);
         emit_byte(cfg_radius, 1'b1, 1'b0);
         emit_byte(cfg_options, 1'b1, 1'b0);
      end
      emit_byte(pb, 1'b1, 1'b0);
      if (17'(pred_byte_count) + 17'd1 >= 17'(n)) begin
         emit_byte(pred_check, 1'b0, 1'b1);
         pred_byte_count = 16'd0;
         pred_check = atfp_pkg::CheckInit;
      end else begin
         pred_byte_count = pred_byte_count + 16'd1;
      end
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_payload(input logic [7:0] b, input int exp_len, input int exp_id);
      int base;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_byte = b;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      base = frame_bytes_due.size();
      pack_byte(b);
      if (exp_len >= 0) begin
         frame_bytes_due[base + 1].frame_byte = exp_len[15:8];
         frame_bytes_due[base + 2].frame_byte = exp_len[7:0];
      end
      if (exp_id >= 0) begin
         frame_bytes_due[base + 4].frame_byte = exp_id[7:0];
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         atfp_pkg::RegPayloadLength: cfg_payload_len = value[15:0];
         atfp_pkg::RegDestAddress:   cfg_dest = value;
         atfp_pkg::RegHopRadius:     cfg_radius = value[7:0];
         atfp_pkg::RegTxOptions:     cfg_options = value[7:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (frame_bytes_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (reset || !idle_on) begin
         rsp_ready = 1'b1;
         ready_hold = 0;
      end else if (ready_hold != 0) begin
         ready_hold = ready_hold - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready = 1'b0;
         ready_hold = $urandom_range(0, 18);
      end else begin
         rsp_ready = 1'b1;
         ready_hold = $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin
      frame_out_type due;
      if (!reset && rsp_if.valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            $error("frame_byte: expected none, actual %02h", rsp_if.frame_byte);
            mismatches++;
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_if.frame_byte !== due.frame_byte) begin
               $error("frame_byte: expected %02h, actual %02h", due.frame_byte,
                      rsp_if.frame_byte);
               mismatches++;
            end
            if (rsp_if.frame_end !== due.frame_end) begin
               $error("frame_end: expected %0b, actual %0b", due.frame_end,
                      rsp_if.frame_end);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CycleLimit) begin
         $display("api_transmit_frame_packer regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < NumRows; r++) begin
         if (directed_rows[r].kind == RowWrite) begin
            wait_drained();
            write_reg(directed_rows[r].index, directed_rows[r].value);
         end else begin
            send_payload(directed_rows[r].value[7:0], directed_rows[r].exp_len,
                         directed_rows[r].exp_id);
         end
      end

      // one-byte frames back to back
      wait_drained();
      write_reg(atfp_pkg::RegPayloadLength, 64'd1);
      repeat (40) begin
         send_payload(8'($urandom_range(0, 255)), -1, -1);
      end

      // random settings; a partial frame carries over into the next setting
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       write_reg(atfp_pkg::RegPayloadLength, 64'd0);
            1:       write_reg(atfp_pkg::RegPayloadLength,
                               64'($urandom_range(65521, 65535)));
            2, 3:    write_reg(atfp_pkg::RegPayloadLength, 64'($urandom_range(9, 60)));
            default: write_reg(atfp_pkg::RegPayloadLength, 64'($urandom_range(1, 8)));
         endcase
         if ($urandom_range(0, 1) == 0) begin
            write_reg(atfp_pkg::RegDestAddress, {$urandom, $urandom});
         end
         if ($urandom_range(0, 1) == 0) begin
            write_reg(atfp_pkg::RegHopRadius, 64'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 1) == 0) begin
            write_reg(atfp_pkg::RegTxOptions, 64'($urandom_range(0, 255)));
         end
         repeat ($urandom_range(14, 20)) begin
            send_payload(8'($urandom_range(0, 255)), -1, -1);
         end
      end

      // short frames at full rate, no idling
      wait_drained();
      idle_on = 1'b0;
      write_reg(atfp_pkg::RegDestAddress, {$urandom, $urandom});
      write_reg(atfp_pkg::RegPayloadLength, 64'($urandom_range(1, 8)));
      repeat (30) begin
         send_payload(8'($urandom_range(0, 255)), -1, -1);
      end

      wait_drained();
      repeat (24) @(negedge clock);
      if (mismatches == 0) begin
         $display("api_transmit_frame_packer regression: pass");
      end else begin
         $display("api_transmit_frame_packer regression: fail");
      end
      $finish;
   end

endmodule
